@@ design/aes_pkg.sv @@
package aes_pkg;

   typedef logic [127:0] block_type;

   typedef enum logic [0:0] {
      REG_KEY_HIGH = 1'b0,
      REG_KEY_LOW  = 1'b1
   } reg_index_type;

   localparam int NumRounds = 10;

   // Byte i of a block sits in bits 127-8i down to 120-8i.
   function automatic logic [7:0] get_byte(input block_type b, input int i);
      get_byte = b[127 - 8 * i -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] tbl [256];
      tbl = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      sbox = tbl[x];
   endfunction

   // Next round key from the previous one and this round's constant.
   function automatic block_type next_key(input block_type k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      next_key = {w0, w1, w2, w3};
   endfunction

   localparam logic [7:0] RCON [NumRounds] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   localparam int ShiftMap [16] = '{0, 5, 10, 15, 4, 9, 14, 3, 8, 13, 2, 7, 12, 1, 6, 11};

endpackage

@@ design/aes_stream_if.sv @@
interface aes_stream_if;
   import aes_pkg::*;
   logic      valid;
   logic      ready;
   block_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ design/aes_csr_if.sv @@
interface aes_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [63:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/aes_round.sv @@
// One cipher round stage: SubBytes, ShiftRows, optional MixColumns, AddRoundKey,
// plus the key schedule step for this round. Holds when the stage ahead stalls.
module aes_round #(
   parameter int RoundIdx = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                valid_in,
   input  aes_pkg::block_type  state_in,
   input  aes_pkg::block_type  key_in,
   output logic                valid_out,
   output aes_pkg::block_type  state_out,
   output aes_pkg::block_type  key_out
);
   import aes_pkg::*;

   block_type  key_in_w, state_in_w;
   logic [7:0] sb [16];
   logic [7:0] mc [16];
   logic       valid_ff;
   block_type  state_ff, key_ff;

   always_comb begin
      key_in_w = next_key(key_in, RCON[RoundIdx]);
      for (int i = 0; i < 16; i++) begin
         sb[i] = sbox(get_byte(state_in, ShiftMap[i]));
      end
      for (int c = 0; c < 4; c++) begin
         if (RoundIdx < NumRounds - 1) begin
            mc[4*c]   = xtime(sb[4*c]) ^ xtime(sb[4*c+1]) ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
            mc[4*c+1] = sb[4*c] ^ xtime(sb[4*c+1]) ^ xtime(sb[4*c+2]) ^ sb[4*c+2] ^ sb[4*c+3];
            mc[4*c+2] = sb[4*c] ^ sb[4*c+1] ^ xtime(sb[4*c+2]) ^ xtime(sb[4*c+3]) ^ sb[4*c+3];
            mc[4*c+3] = xtime(sb[4*c]) ^ sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ xtime(sb[4*c+3]);
         end else begin
            for (int r = 0; r < 4; r++) mc[4*c+r] = sb[4*c+r];
         end
      end
      for (int i = 0; i < 16; i++) begin
         state_in_w[127 - 8*i -: 8] = mc[i] ^ key_in_w[127 - 8*i -: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         state_ff <= state_in_w;
         key_ff   <= key_in_w;
      end
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
   assign key_out   = key_ff;
endmodule

@@ design/aes128_block_encrypt_top.sv @@
// AES-128 encryption pipeline. A block is taken on every cycle in which
// req.ready is high, and its ciphertext is presented on rsp once it has passed
// through 11 register stages: one stage for the initial key
// addition and one per round, each stage carrying its block and its own round
// key, so a key write affects only blocks accepted afterward. With rsp.ready
// held high a new block can enter every cycle. The whole pipeline advances only
// when its last stage is empty or being taken, so a stalled result holds every
// stage in place. Key writes are always accepted.
module aes128_block_encrypt_top (
   input logic           clock,
   input logic           reset,
   aes_stream_if.sink    req,
   aes_stream_if.source  rsp,
   aes_csr_if.sink       csr
);
   import aes_pkg::*;

   logic [63:0] key_high_ff, key_low_ff;
   logic        en;
   logic        v0_ff;
   block_type   s0_ff, k0_ff;
   logic        v [NumRounds+1];
   block_type   s [NumRounds+1];
   block_type   k [NumRounds+1];

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_KEY_HIGH: key_high_ff <= csr.data;
            REG_KEY_LOW:  key_low_ff  <= csr.data;
            default: ;
         endcase
      end
   end

   assign en        = !v[NumRounds] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req.valid;
      end
      if (en) begin
         s0_ff <= req.data ^ {key_high_ff, key_low_ff};
         k0_ff <= {key_high_ff, key_low_ff};
      end
   end

   assign v[0] = v0_ff;
   assign s[0] = s0_ff;
   assign k[0] = k0_ff;

   for (genvar r = 0; r < NumRounds; r++) begin : g_round
      aes_round #(.RoundIdx(r)) u_round (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (v[r]),
         .state_in  (s[r]),
         .key_in    (k[r]),
         .valid_out (v[r+1]),
         .state_out (s[r+1]),
         .key_out   (k[r+1])
      );
   end

   assign rsp.valid = v[NumRounds];
   assign rsp.data  = s[NumRounds];
endmodule
